>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl files
// both expect signals named clock and reset in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its condition
`define ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// property that must hold in the cycle after its condition
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/mcft_pkg.sv
package mcft_pkg;

   // item table size, 1 to 1024 with a 10-bit item id
   localparam int ITEM_SLOTS = 1024;
   localparam int SLOT_W     = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;

   // field widths
   localparam int REQ_W      = 2;
   localparam int ID_W       = 10;
   localparam int COUNT_W    = 16;
   localparam int TOTAL_W    = 24;
   localparam int DISTINCT_W = 11;
   localparam int AGE_W      = 16;
   localparam int REASON_W   = 2;
   localparam int EPOCH_W    = 8;

   // configuration port
   localparam int PADDR_W    = 5;
   localparam int PDATA_W    = 32;
   localparam int CSR_IDX_W  = 3;

   // cross-multiply product widths
   localparam int PROD_S_W   = COUNT_W + AGE_W;
   localparam int PROD_T_W   = TOTAL_W + AGE_W;

   localparam logic [ID_W:0] SLOT_LIMIT = (ID_W + 1)'(ITEM_SLOTS);

   // request kinds
   localparam logic [REQ_W-1:0] REQ_MISS = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOAD = 2'd2;

   // trigger reasons
   localparam logic [REASON_W-1:0] REASON_NONE     = 2'd0;
   localparam logic [REASON_W-1:0] REASON_SINGLE   = 2'd1;
   localparam logic [REASON_W-1:0] REASON_DISTINCT = 2'd2;
   localparam logic [REASON_W-1:0] REASON_TOTAL    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_LIMIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTINCT_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_ENABLE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FRAMES   = 3'd4;

   // one entry of the count memory, live only when its epoch is current
   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [COUNT_W-1:0] count;
   } slot_type;

   // limits seen by the checker
   typedef struct packed {
      logic [COUNT_W-1:0] single_lim;
      logic [COUNT_W-1:0] distinct_lim;
      logic [TOTAL_W-1:0] total_lim;
   } limits_type;

   // counts after one step plus the decay fraction num / den
   typedef struct packed {
      logic                  miss;
      logic [COUNT_W-1:0]    largest;
      logic [DISTINCT_W-1:0] distinct;
      logic [TOTAL_W-1:0]    total;
      logic [AGE_W-1:0]      num;
      logic [AGE_W-1:0]      den;
   } check_type;

   // checker verdict with the counts it belongs to
   typedef struct packed {
      logic [REASON_W-1:0]   reason;
      logic [COUNT_W-1:0]    largest;
      logic [DISTINCT_W-1:0] distinct;
      logic [TOTAL_W-1:0]    total;
   } verdict_type;

endpackage

>>> hdl/mcft_if.sv
// miss / tick / load request channel
interface mcft_req_if import mcft_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [ID_W-1:0]  item_id;

   modport source (output valid, req_type, item_id, input ready);
   modport sink   (input valid, req_type, item_id, output ready);
endinterface

// result channel
interface mcft_rsp_if import mcft_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  load_request;
   logic [REASON_W-1:0]   trigger_reason;
   logic [TOTAL_W-1:0]    total_misses;
   logic [DISTINCT_W-1:0] distinct_misses;
   logic [COUNT_W-1:0]    largest_single;

   modport source (output valid, load_request, trigger_reason, total_misses,
                   distinct_misses, largest_single, input ready);
   modport sink   (input valid, load_request, trigger_reason, total_misses,
                   distinct_misses, largest_single, output ready);
endinterface

>>> hdl/mcft_count_mem.sv
module mcft_count_mem import mcft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              sweep_start,
   output logic              sweep_busy,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output slot_type          rd_data,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  slot_type          wr_data
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ITEM_SLOTS - 1);

   slot_type          mem [ITEM_SLOTS];
   slot_type          rd_data_ff;
   logic              busy_ff;
   logic              busy_in;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] idx_in;

   // sweep sequencer: after reset and on request, zero every entry
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_SLOT) begin
            busy_in = 1'b0;
         end
      end else if (sweep_start) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // storage, read returns the old word on a same-cycle write
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign sweep_busy = busy_ff;
   assign rd_data    = rd_data_ff;

endmodule

>>> hdl/mcft_limit_check.sv
module mcft_limit_check import mcft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        chk_valid,
   input  check_type   chk,
   input  limits_type  limits,
   output logic        verdict_valid,
   output verdict_type verdict
);

   logic                  valid_ff;
   logic                  miss_ff;
   logic [COUNT_W-1:0]    largest_ff;
   logic [DISTINCT_W-1:0] distinct_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic [PROD_S_W-1:0]   single_cnt_ff;
   logic [PROD_S_W-1:0]   single_lim_ff;
   logic [PROD_S_W-1:0]   distinct_cnt_ff;
   logic [PROD_S_W-1:0]   distinct_lim_ff;
   logic [PROD_T_W-1:0]   total_cnt_ff;
   logic [PROD_T_W-1:0]   total_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= chk_valid;
      end
   end

   // cross products: count * den against limit * num
   always_ff @(posedge clock) begin
      if (advance) begin
         miss_ff         <= chk.miss;
         largest_ff      <= chk.largest;
         distinct_ff     <= chk.distinct;
         total_ff        <= chk.total;
         single_cnt_ff   <= PROD_S_W'(chk.largest) * PROD_S_W'(chk.den);
         single_lim_ff   <= PROD_S_W'(limits.single_lim) * PROD_S_W'(chk.num);
         distinct_cnt_ff <= PROD_S_W'(chk.distinct) * PROD_S_W'(chk.den);
         distinct_lim_ff <= PROD_S_W'(limits.distinct_lim) * PROD_S_W'(chk.num);
         total_cnt_ff    <= PROD_T_W'(chk.total) * PROD_T_W'(chk.den);
         total_lim_ff    <= PROD_T_W'(limits.total_lim) * PROD_T_W'(chk.num);
      end
   end

   // priority compare: single, then distinct, then total
   always_comb begin
      verdict.reason = REASON_NONE;
      if (miss_ff) begin
         if (single_cnt_ff > single_lim_ff) begin
            verdict.reason = REASON_SINGLE;
         end else if (distinct_cnt_ff > distinct_lim_ff) begin
            verdict.reason = REASON_DISTINCT;
         end else if (total_cnt_ff > total_lim_ff) begin
            verdict.reason = REASON_TOTAL;
         end
      end
      verdict.largest  = largest_ff;
      verdict.distinct = distinct_ff;
      verdict.total    = total_ff;
   end

   assign verdict_valid = valid_ff;

endmodule

>>> hdl/miss_count_cache_fill_trigger_top.sv
// An accepted request beat passes the stage 1, stage 2, checker and result registers.
// Throughput: one request per cycle while not stalled; the count memory read-modify-write is closed
// by forwarding the last write, and a stalled result beat stalls the whole pipe.
// Reset clears all control state, then a sweep zeroes the count memory with no requests
// taken; every 256th clearing load repeats that sweep.
`include "assert_macros.svh"

module miss_count_cache_fill_trigger_top import mcft_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   mcft_req_if.sink           req_chan,
   mcft_rsp_if.source         rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   // configuration registers
   logic [COUNT_W-1:0] single_limit_ff;
   logic [COUNT_W-1:0] distinct_limit_ff;
   logic [TOTAL_W-1:0] total_limit_ff;
   logic               clear_enable_ff;
   logic [AGE_W-1:0]   decay_frames_ff;
   logic               csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   // pipeline control
   logic advance;
   logic req_accept;
   logic wrap_hold;
   logic sweep_busy;
   logic sweep_start;

   // stage 1: request plus memory read
   logic             s1_valid_ff;
   logic [REQ_W-1:0] s1_req_ff;
   logic [ID_W-1:0]  s1_id_ff;
   slot_type         rd_data;
   logic [SLOT_W-1:0] s1_slot;
   logic             s1_miss;
   logic             s1_step;

   // running state
   logic [TOTAL_W-1:0]    total_ff,    total_in;
   logic [DISTINCT_W-1:0] distinct_ff, distinct_in;
   logic [COUNT_W-1:0]    max_ff,      max_in;
   logic [AGE_W-1:0]      age_ff,      age_in;
   logic [EPOCH_W-1:0]    epoch_ff,    epoch_in;
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [SLOT_W-1:0]     fwd_slot_ff;
   logic [COUNT_W-1:0]    fwd_count_ff;
   logic [COUNT_W-1:0]    old_cnt;
   logic [COUNT_W-1:0]    new_cnt;
   slot_type              wr_data;

   // stage 2: counts and decay fraction
   logic       s2_valid_ff;
   check_type  s2_ff, s2_in;
   limits_type limits;

   // checker and result register
   logic                  verdict_valid;
   verdict_type           verdict;
   logic                  rsp_valid_ff;
   logic                  rsp_load_ff;
   logic [REASON_W-1:0]   rsp_reason_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;
   logic [DISTINCT_W-1:0] rsp_distinct_ff;
   logic [COUNT_W-1:0]    rsp_largest_ff;

   // configuration port
   assign pready    = 1'b1;
   assign csr_idx   = paddr[PADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         single_limit_ff   <= '0;
         distinct_limit_ff <= '0;
         total_limit_ff    <= '0;
         clear_enable_ff   <= 1'b0;
         decay_frames_ff   <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            CSR_SINGLE_LIMIT:   single_limit_ff   <= pwdata[COUNT_W-1:0];
            CSR_DISTINCT_LIMIT: distinct_limit_ff <= pwdata[COUNT_W-1:0];
            CSR_TOTAL_LIMIT:    total_limit_ff    <= pwdata[TOTAL_W-1:0];
            CSR_CLEAR_ENABLE:   clear_enable_ff   <= pwdata[0];
            CSR_DECAY_FRAMES:   decay_frames_ff   <= pwdata[AGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_SINGLE_LIMIT:   prdata = PDATA_W'(single_limit_ff);
         CSR_DISTINCT_LIMIT: prdata = PDATA_W'(distinct_limit_ff);
         CSR_TOTAL_LIMIT:    prdata = PDATA_W'(total_limit_ff);
         CSR_CLEAR_ENABLE:   prdata = PDATA_W'(clear_enable_ff);
         CSR_DECAY_FRAMES:   prdata = PDATA_W'(decay_frames_ff);
         default:            prdata = '0;
      endcase
   end

   // flow control: a clearing load that wraps the epoch holds off new reads
   assign advance    = !rsp_valid_ff || rsp_chan.ready;
   assign wrap_hold  = s1_valid_ff && (s1_req_ff == REQ_LOAD) && clear_enable_ff
                       && (epoch_ff == '1);
   assign req_chan.ready = advance && !sweep_busy && !wrap_hold;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign s1_step    = advance && s1_valid_ff;
   assign sweep_start = s1_step && wrap_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_chan.req_type;
         s1_id_ff  <= req_chan.item_id;
      end
   end

   mcft_count_mem u_count_mem (
      .clock       (clock),
      .reset       (reset),
      .sweep_start (sweep_start),
      .sweep_busy  (sweep_busy),
      .rd_en       (req_accept),
      .rd_addr     (req_chan.item_id[SLOT_W-1:0]),
      .rd_data     (rd_data),
      .wr_en       (s1_step && s1_miss),
      .wr_addr     (s1_slot),
      .wr_data     (wr_data)
   );

   // per-item count: forwarded last write, else memory word if its epoch is live
   assign s1_slot = s1_id_ff[SLOT_W-1:0];
   assign s1_miss = (s1_req_ff == REQ_MISS) && ({1'b0, s1_id_ff} < SLOT_LIMIT);

   always_comb begin
      if (fwd_valid_ff && (fwd_slot_ff == s1_slot)) begin
         old_cnt = fwd_count_ff;
      end else if (rd_data.epoch == epoch_ff) begin
         old_cnt = rd_data.count;
      end else begin
         old_cnt = '0;
      end
      new_cnt       = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
      wr_data.epoch = epoch_ff;
      wr_data.count = new_cnt;
   end

   // state update for the item in stage 1
   always_comb begin
      total_in     = total_ff;
      distinct_in  = distinct_ff;
      max_in       = max_ff;
      age_in       = age_ff;
      epoch_in     = epoch_ff;
      fwd_valid_in = fwd_valid_ff;
      if (s1_miss) begin
         if (total_ff != '1) begin
            total_in = total_ff + 1'b1;
         end
         if ((old_cnt == '0) && (distinct_ff != '1)) begin
            distinct_in = distinct_ff + 1'b1;
         end
         if (new_cnt > max_ff) begin
            max_in = new_cnt;
         end
         fwd_valid_in = 1'b1;
      end else if (s1_req_ff == REQ_TICK) begin
         if (age_ff != '1) begin
            age_in = age_ff + 1'b1;
         end
      end else if (s1_req_ff == REQ_LOAD) begin
         age_in = '0;
         if (clear_enable_ff) begin
            total_in     = '0;
            distinct_in  = '0;
            max_in       = '0;
            epoch_in     = epoch_ff + 1'b1;
            fwd_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         distinct_ff  <= '0;
         max_ff       <= '0;
         age_ff       <= '0;
         epoch_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (s1_step) begin
         total_ff     <= total_in;
         distinct_ff  <= distinct_in;
         max_ff       <= max_in;
         age_ff       <= age_in;
         epoch_ff     <= epoch_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_step && s1_miss) begin
         fwd_slot_ff  <= s1_slot;
         fwd_count_ff <= new_cnt;
      end
   end

   // decay fraction: 1/1 with no decay, else (frames - age) / frames, floored at 0
   always_comb begin
      s2_in.miss     = s1_miss;
      s2_in.largest  = max_in;
      s2_in.distinct = distinct_in;
      s2_in.total    = total_in;
      if (decay_frames_ff == '0) begin
         s2_in.num = AGE_W'(1);
         s2_in.den = AGE_W'(1);
      end else begin
         s2_in.den = decay_frames_ff;
         s2_in.num = (age_ff >= decay_frames_ff) ? '0 : decay_frames_ff - age_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_step) begin
         s2_ff <= s2_in;
      end
   end

   assign limits.single_lim   = single_limit_ff;
   assign limits.distinct_lim = distinct_limit_ff;
   assign limits.total_lim    = total_limit_ff;

   mcft_limit_check u_limit_check (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .chk_valid     (s2_valid_ff),
      .chk           (s2_ff),
      .limits        (limits),
      .verdict_valid (verdict_valid),
      .verdict       (verdict)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= verdict_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_load_ff     <= (verdict.reason != REASON_NONE);
         rsp_reason_ff   <= verdict.reason;
         rsp_total_ff    <= verdict.total;
         rsp_distinct_ff <= verdict.distinct;
         rsp_largest_ff  <= verdict.largest;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.load_request    = rsp_load_ff;
   assign rsp_chan.trigger_reason  = rsp_reason_ff;
   assign rsp_chan.total_misses    = rsp_total_ff;
   assign rsp_chan.distinct_misses = rsp_distinct_ff;
   assign rsp_chan.largest_single  = rsp_largest_ff;

   // checks
   `ASSERT_NOW(a_flag_matches_reason, rsp_valid_ff, rsp_load_ff == (rsp_reason_ff != REASON_NONE), "load_request disagrees with trigger_reason")
   `ASSERT_NOW(a_distinct_within_total, 1'b1, TOTAL_W'(distinct_ff) <= total_ff, "distinct count above total")
   `ASSERT_NOW(a_largest_within_total, 1'b1, TOTAL_W'(max_ff) <= total_ff, "largest count above total")
   `ASSERT_NEXT(a_wrap_starts_sweep, s1_step && wrap_hold, sweep_busy, "epoch wrap did not start a sweep")
   `ASSERT_NOW(a_sweep_stage_empty, sweep_busy, !s1_valid_ff, "request in flight during memory sweep")

endmodule

>>> tb/sv/mcft_fill_checker.sv
// watches the request, result and register ports of the miss-count fill trigger,
// predicts every result beat and compares it with what the block returns
module mcft_fill_checker import mcft_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   mcft_req_if                req_mon,
   mcft_rsp_if                rsp_mon,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output int                 fail_count,
   output int                 open_count
);

   // one predicted result beat
   typedef struct packed {
      logic                  load_request;
      logic [REASON_W-1:0]   reason;
      logic [TOTAL_W-1:0]    total;
      logic [DISTINCT_W-1:0] distinct;
      logic [COUNT_W-1:0]    largest;
   } fill_status_type;

   localparam logic [COUNT_W-1:0]    COUNT_MAX    = {COUNT_W{1'b1}};
   localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = {TOTAL_W{1'b1}};
   localparam logic [DISTINCT_W-1:0] DISTINCT_MAX = {DISTINCT_W{1'b1}};
   localparam logic [AGE_W-1:0]      AGE_MAX      = {AGE_W{1'b1}};

   // shadow of the registers
   logic [COUNT_W-1:0] single_lim;
   logic [COUNT_W-1:0] distinct_lim;
   logic [TOTAL_W-1:0] total_lim;
   logic               clear_en;
   logic [AGE_W-1:0]   decay_frames;

   // predicted counter state
   logic [COUNT_W-1:0]    miss_counts [ITEM_SLOTS];
   bit                    miss_live   [ITEM_SLOTS];
   logic [TOTAL_W-1:0]    total_misses;
   logic [DISTINCT_W-1:0] distinct_misses;
   logic [COUNT_W-1:0]    largest_single;
   logic [AGE_W-1:0]      idle_age;

   fill_status_type status_q [$];
   int              mismatches = 0;

   // exact test of count > limit * num / den
   function automatic bit exceeds(longint unsigned count, longint unsigned limit,
                                  longint unsigned num, longint unsigned den);
      return count * den > limit * num;
   endfunction

   function automatic void clear_counts();
      miss_live       = '{default: 1'b0};
      total_misses    = '0;
      distinct_misses = '0;
      largest_single  = '0;
   endfunction

   // advance the predicted state by one request and return the result it gives
   function automatic fill_status_type predict_fill_status(logic [REQ_W-1:0] kind,
                                                           logic [ID_W-1:0] id);
      fill_status_type    status;
      logic [COUNT_W-1:0] cnt;
      longint unsigned    num;
      longint unsigned    den;
      logic [REASON_W-1:0] reason;
      reason = REASON_NONE;
      if (kind == REQ_MISS && id < ITEM_SLOTS) begin
         cnt = miss_live[id] ? miss_counts[id] : '0;
         if (total_misses != TOTAL_MAX)
            total_misses = total_misses + 1'b1;
         if (cnt == '0 && distinct_misses != DISTINCT_MAX)
            distinct_misses = distinct_misses + 1'b1;
         if (cnt != COUNT_MAX)
            cnt = cnt + 1'b1;
         miss_counts[id] = cnt;
         miss_live[id]   = 1'b1;
         if (cnt > largest_single)
            largest_single = cnt;
         // decay factor num / den, zero once fully aged
         if (decay_frames == '0) begin
            num = 1;
            den = 1;
         end else begin
            den = decay_frames;
            num = (idle_age >= decay_frames) ? 0 : decay_frames - idle_age;
         end
         if (exceeds(largest_single, single_lim, num, den))
            reason = REASON_SINGLE;
         else if (exceeds(distinct_misses, distinct_lim, num, den))
            reason = REASON_DISTINCT;
         else if (exceeds(total_misses, total_lim, num, den))
            reason = REASON_TOTAL;
      end else if (kind == REQ_TICK) begin
         if (idle_age != AGE_MAX)
            idle_age = idle_age + 1'b1;
      end else if (kind == REQ_LOAD) begin
         idle_age = '0;
         if (clear_en)
            clear_counts();
      end
      status.load_request = (reason != REASON_NONE);
      status.reason       = reason;
      status.total        = total_misses;
      status.distinct     = distinct_misses;
      status.largest      = largest_single;
      return status;
   endfunction

   function automatic void note_mismatch(string field, longint unsigned want,
                                         longint unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      fill_status_type want;
      if (reset) begin
         single_lim   = '0;
         distinct_lim = '0;
         total_lim    = '0;
         clear_en     = 1'b0;
         decay_frames = '0;
         miss_counts  = '{default: '0};
         idle_age     = '0;
         clear_counts();
         status_q.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[PADDR_W-1:2])
               CSR_SINGLE_LIMIT:   single_lim   = pwdata[COUNT_W-1:0];
               CSR_DISTINCT_LIMIT: distinct_lim = pwdata[COUNT_W-1:0];
               CSR_TOTAL_LIMIT:    total_lim    = pwdata[TOTAL_W-1:0];
               CSR_CLEAR_ENABLE:   clear_en     = pwdata[0];
               CSR_DECAY_FRAMES:   decay_frames = pwdata[AGE_W-1:0];
               default: ;
            endcase
         end
         // result beats against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_q.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with no request waiting, expected none, actual %0d",
                        $time, rsp_mon.total_misses);
            end else begin
               want = status_q.pop_front();
               if (rsp_mon.load_request !== want.load_request)
                  note_mismatch("load_request", want.load_request, rsp_mon.load_request);
               if (rsp_mon.trigger_reason !== want.reason)
                  note_mismatch("trigger_reason", want.reason, rsp_mon.trigger_reason);
               if (rsp_mon.total_misses !== want.total)
                  note_mismatch("total_misses", want.total, rsp_mon.total_misses);
               if (rsp_mon.distinct_misses !== want.distinct)
                  note_mismatch("distinct_misses", want.distinct, rsp_mon.distinct_misses);
               if (rsp_mon.largest_single !== want.largest)
                  note_mismatch("largest_single", want.largest, rsp_mon.largest_single);
            end
         end
         // request beats
         if (req_mon.valid && req_mon.ready)
            status_q.push_back(predict_fill_status(req_mon.req_type, req_mon.item_id));
      end
      fail_count <= mismatches;
      open_count <= status_q.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// stimulus and verdict for the miss-count fill trigger
module tb_top import mcft_pkg::*; ();

   localparam logic [REQ_W-1:0] REQ_SPARE      = 2'd3;
   localparam int               WATCHDOG_LIMIT = 5000;
   localparam int               HOLD_CYCLES    = 150;
   localparam int               BLOCK_ITEMS    = 190;
   localparam int               COUNT_TOP      = 65535;
   localparam int               TOTAL_TOP      = 24'hFFFFFF;

   logic               clock = 1'b0;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   int fail_count;
   int open_count;
   int idle_mode    = 0;
   int hold_left    = 0;
   int rsp_beats    = 0;
   int quiet_cycles = 0;

   mcft_req_if req_bus ();
   mcft_rsp_if rsp_bus ();

   miss_count_cache_fill_trigger_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mcft_fill_checker fill_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always #6 clock = ~clock;

   // idle percentages per mode: sender light then heavy, then none
   function automatic int sender_idle_pct();
      case (idle_mode)
         0:       return 38;
         1:       return 64;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_mode)
         0:       return 64;
         1:       return 38;
         default: return 0;
      endcase
   endfunction

   // result side: random stalls plus long hold-offs at two points of the run
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready)
         rsp_beats <= rsp_beats + 1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready && (rsp_beats == 299 || rsp_beats == 999)) begin
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // one request beat, with random idle cycles ahead of it
   task automatic send_item(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id);
      int gap_pct;
      gap_pct = sender_idle_pct();
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.item_id  <= id;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // setup then access; psel stays high across back-to-back writes
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
   endtask

   task automatic program_csrs(int unsigned single_lim, int unsigned distinct_lim,
                               int unsigned total_lim, int unsigned clear_en,
                               int unsigned decay);
      wait_drained();
      csr_write(CSR_SINGLE_LIMIT, single_lim);
      csr_write(CSR_DISTINCT_LIMIT, distinct_lim);
      csr_write(CSR_TOTAL_LIMIT, total_lim);
      csr_write(CSR_CLEAR_ENABLE, clear_en);
      csr_write(CSR_DECAY_FRAMES, decay);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // limits: zero, the top value, or small enough to trip often
   function automatic int unsigned pick_limit(int unsigned top, int unsigned low_top);
      case ($urandom_range(3))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(low_top);
      endcase
   endfunction

   function automatic int unsigned pick_decay();
      case ($urandom_range(4))
         0:       return 0;
         1:       return 1;
         2:       return COUNT_TOP;
         default: return $urandom_range(24, 2);
      endcase
   endfunction

   // half the ids from a small hot set so single counts climb
   function automatic logic [ID_W-1:0] pick_id(int span);
      if ($urandom_range(1))
         return ID_W'($urandom_range(span - 1));
      return ID_W'($urandom_range(ITEM_SLOTS - 1));
   endfunction

   // one random phase under a fresh register setting
   task automatic random_block(int count);
      int                 span;
      int                 roll;
      logic [REQ_W-1:0]   kind;
      program_csrs(pick_limit(COUNT_TOP, 12), pick_limit(COUNT_TOP, 40),
                   pick_limit(TOTAL_TOP, 200), $urandom_range(1), pick_decay());
      span = $urandom_range(32, 1);
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 68)
            kind = REQ_MISS;
         else if (roll < 82)
            kind = REQ_TICK;
         else if (roll < 94)
            kind = REQ_LOAD;
         else
            kind = REQ_SPARE;
         send_item(kind, pick_id(span));
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_MISS;
      req_bus.item_id  <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // no decay, single limit trips on the fourth hit, extreme ids, spare type
      program_csrs(3, COUNT_TOP, TOTAL_TOP, 1, 0);
      repeat (4) send_item(REQ_MISS, '0);
      send_item(REQ_MISS, '1);
      send_item(REQ_SPARE, '1);
      send_item(REQ_TICK, 10'd341);
      send_item(REQ_LOAD, 10'd682);
      send_item(REQ_MISS, '0);

      // distinct limit, and a load that keeps the counts
      program_csrs(COUNT_TOP, 1, TOTAL_TOP, 0, 0);
      send_item(REQ_MISS, 10'd1);
      send_item(REQ_LOAD, 10'd1);
      send_item(REQ_MISS, 10'd1);

      // total limit, then a clearing load
      program_csrs(COUNT_TOP, COUNT_TOP, 5, 1, 0);
      repeat (3) send_item(REQ_MISS, 10'd2);
      send_item(REQ_LOAD, 10'd2);

      // limits fully decayed after two ticks
      program_csrs(COUNT_TOP, COUNT_TOP, TOTAL_TOP, 1, 2);
      send_item(REQ_MISS, 10'd512);
      repeat (2) send_item(REQ_TICK, 10'd512);
      send_item(REQ_MISS, 10'd512);
      send_item(REQ_TICK, 10'd512);
      send_item(REQ_LOAD, 10'd512);

      // random phases, two per idle mode
      for (int mode = 0; mode < 3; mode++) begin
         idle_mode = mode;
         repeat (2) random_block(BLOCK_ITEMS);
      end

      // longest decay window, with a clearing load between two hits
      program_csrs(COUNT_TOP, COUNT_TOP, TOTAL_TOP, 1, COUNT_TOP);
      send_item(REQ_MISS, 10'd200);
      send_item(REQ_LOAD, 10'd200);
      send_item(REQ_MISS, 10'd200);

      wait_drained();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
